/* src/daily_task_alarm_scheduler_macros.svh */
// Assertion macros shared by the daily task alarm scheduler RTL.
`ifndef DAILY_TASK_ALARM_SCHEDULER_MACROS_SVH
`define DAILY_TASK_ALARM_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DTAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");
// Next-cycle implication, disabled during reset.
`define DTAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");
`else
`define DTAS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define DTAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/dtas_pkg.sv */
// Shared types and constants of the daily task alarm scheduler.
package dtas_pkg;

    localparam int TABLE_DEPTH     = 16;
    localparam int SECONDS_PER_DAY = 24 * 60 * 60;
    localparam int TIME_W          = 17;
    localparam int ID_W            = 8;
    localparam int IDX_W           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W         = TIME_W + ID_W;

    localparam logic [TIME_W-1:0] MAX_TIME = TIME_W'(SECONDS_PER_DAY - 1);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // One table entry: start time over task id.
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Outcome of the shared time comparator.
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_t;

    // One result item.
    typedef struct packed {
        logic            fire;
        logic [ID_W-1:0] fired_task_id;
        logic            late;
        logic [1:0]      status;
    } result_t;

endpackage

/* src/dtas_table.sv */
// Task table memory: one write port and one registered read port.
module dtas_table
    import dtas_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    // Write one entry and register the read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/dtas_cmp.sv */
// Shared comparator of the working time against a table start time.
module dtas_cmp
    import dtas_pkg::*;
(
    input  logic [TIME_W-1:0] now,
    input  logic [TIME_W-1:0] start_time,
    output cmp_t              res
);

    // Compare once; every command reads its own relation from this.
    assign res.lt = (now < start_time);
    assign res.gt = (now > start_time);

endmodule

/* src/dtas_ctrl.sv */
// Sequencer of the scheduler: insertion, start search and tick handling.
module dtas_ctrl
    import dtas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [1:0]        cmd,
    input  logic [TIME_W-1:0] time_of_day,
    input  logic [ID_W-1:0]   task_id,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_CMP,
        S_ST_RD,
        S_ST_CMP,
        S_TK_RD,
        S_TK_CMP,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [TIME_W-1:0] t_reg, t_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              armed_reg, armed_next;
    logic              wait_reg, wait_next;
    logic [TIME_W-1:0] prev_reg, prev_next;
    result_t           res_reg, res_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            mem_rdata;
    cmp_t              cmp;

    logic [TIME_W-1:0] t_sat;
    logic              tick_wait;
    logic [CNT_W-1:0]  idx_dec;
    logic [CNT_W-1:0]  slot_inc;

    dtas_table u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    dtas_cmp u_cmp (
        .now        (t_reg),
        .start_time (mem_rdata.start_time),
        .res        (cmp)
    );

    // Clamp the incoming time to the last second of the day.
    assign t_sat = (time_of_day > MAX_TIME) ? MAX_TIME : time_of_day;

    // Midnight wait survives a tick unless time went backwards.
    assign tick_wait = wait_reg && !(t_sat < prev_reg);

    assign idx_dec  = idx_reg - CNT_W'(1);
    assign slot_inc = CNT_W'(slot_reg) + CNT_W'(1);

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

    // Sequence one item through the table.
    always_comb
    begin
        state_next = state_reg;
        t_next     = t_reg;
        id_next    = id_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        slot_next  = slot_reg;
        armed_next = armed_reg;
        wait_next  = wait_reg;
        prev_next  = prev_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg[IDX_W-1:0];
        mem_wdata  = '{start_time: t_reg, id: id_reg};
        mem_re     = 1'b0;
        mem_raddr  = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    t_next   = t_sat;
                    id_next  = task_id;
                    res_next = '0;
                    priority if (cmd == CMD_LOAD)
                    begin
                        // Any load disarms, the table order changes.
                        armed_next = 1'b0;
                        wait_next  = 1'b0;
                        slot_next  = '0;
                        if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next   = count_reg;
                            state_next = S_LD_RD;
                        end
                    end
                    else if (cmd == CMD_START)
                    begin
                        if (count_reg == '0)
                        begin
                            armed_next      = 1'b0;
                            wait_next       = 1'b0;
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_ST_RD;
                        end
                    end
                    else if (cmd == CMD_TICK)
                    begin
                        if (!armed_reg || (count_reg == '0))
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            prev_next = t_sat;
                            wait_next = tick_wait;
                            if (CNT_W'(slot_reg) >= count_reg)
                            begin
                                slot_next = '0;
                            end
                            state_next = tick_wait ? S_DONE : S_TK_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_LD_RD:
            begin
                // Reached the bottom: drop the new entry into place.
                if (idx_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = idx_dec[IDX_W-1:0];
                    state_next = S_LD_CMP;
                end
            end

            S_LD_CMP:
            begin
                if (cmp.lt)
                begin
                    // Entry below starts later: move it up one place.
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    idx_next   = idx_dec;
                    state_next = S_LD_RD;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_ST_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // Nothing left today: arm at the first entry for tomorrow.
                    slot_next  = '0;
                    wait_next  = 1'b1;
                    armed_next = 1'b1;
                    prev_next  = t_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_ST_CMP;
                end
            end

            S_ST_CMP:
            begin
                if (cmp.gt)
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_ST_RD;
                end
                else
                begin
                    slot_next  = idx_reg[IDX_W-1:0];
                    wait_next  = 1'b0;
                    armed_next = 1'b1;
                    prev_next  = t_reg;
                    state_next = S_DONE;
                end
            end

            S_TK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = slot_reg;
                state_next = S_TK_CMP;
            end

            S_TK_CMP:
            begin
                if (!cmp.lt)
                begin
                    res_next.fire          = 1'b1;
                    res_next.fired_task_id = mem_rdata.id;
                    res_next.late          = cmp.gt;
                    // Advance cyclically; a wrap waits for midnight.
                    if (slot_inc >= count_reg)
                    begin
                        slot_next = '0;
                        wait_next = 1'b1;
                    end
                    else
                    begin
                        slot_next = slot_inc[IDX_W-1:0];
                    end
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, working registers and the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            slot_reg  <= '0;
            armed_reg <= 1'b0;
            wait_reg  <= 1'b0;
            prev_reg  <= '0;
            t_reg     <= '0;
            id_reg    <= '0;
            idx_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            slot_reg  <= slot_next;
            armed_reg <= armed_next;
            wait_reg  <= wait_next;
            prev_reg  <= prev_next;
            t_reg     <= t_next;
            id_reg    <= id_next;
            idx_reg   <= idx_next;
            res_reg   <= res_next;
        end
    end

endmodule

/* src/daily_task_alarm_scheduler.sv */
// Top level of the daily task alarm scheduler with its output register.
//
// Each transfer on the item channel yields exactly one transfer on the result
// channel. The block takes one item at a time and drops item_ready until the
// item is finished and its result has moved into the output register, which
// can still hold the previous result while the next item is worked on. The
// task table is a single-port-read memory walked by one shared time
// comparator, with a read state and a compare state per entry visited. A
// tick reads the current slot entry, or none while it waits for midnight; a
// start walks past every entry earlier than the current time; a load moves
// every entry that starts later than the new one up one place. Full loads,
// empty starts, ticks while not armed and the unused command do not touch
// the table. No clearing pass runs after reset.
`include "daily_task_alarm_scheduler_macros.svh"

module daily_task_alarm_scheduler
    import dtas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [1:0]        cmd,
    input  logic [TIME_W-1:0] time_of_day,
    input  logic [ID_W-1:0]   task_id,
    output logic              result_valid,
    input  logic              result_ready,
    output logic              fire,
    output logic [ID_W-1:0]   fired_task_id,
    output logic              late,
    output logic [1:0]        status
);

    logic    res_valid;
    logic    res_ready;
    result_t res;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    dtas_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .cmd         (cmd),
        .time_of_day (time_of_day),
        .task_id     (task_id),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Take a new result whenever the output slot is empty or being drained.
    assign res_ready = !out_valid_reg || result_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold the output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output payload.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign result_valid  = out_valid_reg;
    assign fire          = out_reg.fire;
    assign fired_task_id = out_reg.fired_task_id;
    assign late          = out_reg.late;
    assign status        = out_reg.status;

    // A result without a release carries no id and no late flag.
    `DTAS_ASSERT_NOW(a_idle_fields, clk, rst_n, result_valid && !fire, (fired_task_id == '0) && !late)
    // A release only comes with status ok.
    `DTAS_ASSERT_NOW(a_fire_ok, clk, rst_n, result_valid && fire, status == ST_OK)
    // The sequencer is busy right after taking an item.
    `DTAS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, item_valid && item_ready, !item_ready)

endmodule
